// ----- src/dcms_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcms_pkg
// Shared widths, register codes and helpers for the DC-blocked mean-square
// detector.
// ----------------------------------------------------------------------------
package dcms_pkg;

   localparam int SAMPLE_BITS_DEFAULT = 12;
   localparam int HP_ACC_BITS         = 32;
   localparam int AV_ACC_BITS         = 40;
   localparam int MAG_BITS            = 31;
   localparam int OUT_BITS            = 24;
   localparam int SHIFT_BITS          = 5;
   localparam int CSR_INDEX_BITS      = 1;
   localparam int CSR_DATA_BITS       = 5;

   localparam logic [SHIFT_BITS-1:0] SHIFT_MIN          = 5'd1;
   localparam logic [SHIFT_BITS-1:0] SHIFT_MAX          = 5'd16;
   localparam logic [SHIFT_BITS-1:0] HIGHPASS_SHIFT_RST = 5'd12;
   localparam logic [SHIFT_BITS-1:0] AVERAGE_SHIFT_RST  = 5'd9;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_HIGHPASS_SHIFT = 1'b0,
      CSR_AVERAGE_SHIFT  = 1'b1
   } csr_index_type;

   function automatic logic [SHIFT_BITS-1:0] clamp_shift(input logic [SHIFT_BITS-1:0] v);
      logic [SHIFT_BITS-1:0] r;
      if (v < SHIFT_MIN) begin
         r = SHIFT_MIN;
      end else if (v > SHIFT_MAX) begin
         r = SHIFT_MAX;
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

// ----- src/dcms_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcms_req_if / dcms_rsp_if
// Valid/ready channels carrying samples in and mean-square values out.
// ----------------------------------------------------------------------------
interface dcms_req_if #(
   parameter int SAMPLE_BITS = dcms_pkg::SAMPLE_BITS_DEFAULT
);
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface dcms_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [dcms_pkg::OUT_BITS-1:0] mean_square;

   modport source (output valid, output mean_square, input ready);
   modport sink   (input valid, input mean_square, output ready);
endinterface

// ----- src/dc_blocked_mean_square_detector_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dc_blocked_mean_square_detector_top
// DC-removing highpass, square (low 40 bits kept) and one-pole smoothing of the square.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one unsigned converter sample per transfer; rsp_ch returns
//   one smoothed mean-square value per sample, in order.
//   csr_wr_en/csr_index/csr_wr_data write the highpass shift (index 0) and
//   the averaging shift (index 1); values outside 1..16 are clamped.
//   Write them only while no sample is in flight.
// Timing:
//   Four register stages: input, highpass/magnitude, square, smoothing.
//   A sample passes the input, highpass/magnitude, square and smoothing
//   registers to rsp_ch; throughput is one sample per cycle unless rsp_ch
//   stalls; each accumulator gets one add and shift as its item advances.
// Reset:
//   Synchronous; clears both accumulators and all stage valids, and loads the
//   shifts with 12 and 9.
// Stalls:
//   Each stage holds its item while the next is full and stalled; bubbles
//   close up, so req_ch keeps taking samples until all four stages are full.
// ----------------------------------------------------------------------------
module dc_blocked_mean_square_detector_top #(
   parameter int SAMPLE_BITS = dcms_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   dcms_req_if.sink                            req_ch,
   dcms_rsp_if.source                          rsp_ch,
   input  logic                                csr_wr_en,
   input  logic [dcms_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [dcms_pkg::CSR_DATA_BITS-1:0]  csr_wr_data
);

   localparam int HPB = dcms_pkg::HP_ACC_BITS;
   localparam int AVB = dcms_pkg::AV_ACC_BITS;
   localparam int MGB = dcms_pkg::MAG_BITS;
   localparam int SHB = dcms_pkg::SHIFT_BITS;

   logic [SHB-1:0]         hp_shift_ff, hp_shift_in;
   logic [SHB-1:0]         av_shift_ff, av_shift_in;
   logic [HPB-1:0]         hp_acc_ff, hp_acc_in;
   logic [AVB-1:0]         av_acc_ff, av_acc_in;

   logic                   v0_ff, v0_in;
   logic                   v1_ff, v1_in;
   logic                   v2_ff, v2_in;
   logic                   v3_ff, v3_in;
   logic [SAMPLE_BITS-1:0] sample0_ff, sample0_in;
   logic [MGB-1:0]         mag1_ff, mag1_in;
   logic [AVB-1:0]         sq2_ff, sq2_in;
   logic [dcms_pkg::OUT_BITS-1:0] ms3_ff, ms3_in;

   logic                   ld0, ld1, ld2, ld3;
   logic [SHB:0]           hp_sh1, av_sh1;
   logic [HPB:0]           hp_sum;
   logic [MGB-1:0]         dc, samp_ext;
   logic [2*MGB-1:0]       sq_full;
   logic [AVB:0]           av_sum;

   // stage load enables, bubbles collapse
   assign ld3 = !v3_ff || rsp_ch.ready;
   assign ld2 = !v2_ff || ld3;
   assign ld1 = !v1_ff || ld2;
   assign ld0 = !v0_ff || ld1;

   assign req_ch.ready       = ld0;
   assign rsp_ch.valid       = v3_ff;
   assign rsp_ch.mean_square = ms3_ff;

   // csr decode
   always_comb begin
      hp_shift_in = hp_shift_ff;
      av_shift_in = av_shift_ff;
      if (csr_wr_en) begin
         unique case (dcms_pkg::csr_index_type'(csr_index))
            dcms_pkg::CSR_HIGHPASS_SHIFT: hp_shift_in = dcms_pkg::clamp_shift(csr_wr_data);
            dcms_pkg::CSR_AVERAGE_SHIFT:  av_shift_in = dcms_pkg::clamp_shift(csr_wr_data);
         endcase
      end
   end

   // datapath
   always_comb begin
      hp_sh1   = {1'b0, hp_shift_ff} + (SHB+1)'(1);
      av_sh1   = {1'b0, av_shift_ff} + (SHB+1)'(1);

      // stage 1: DC removal and magnitude
      hp_acc_in = hp_acc_ff - (hp_acc_ff >> hp_shift_ff) + HPB'(sample0_ff);
      hp_sum    = {1'b0, hp_acc_in} + {1'b0, hp_acc_ff};
      dc        = MGB'(hp_sum >> hp_sh1);
      samp_ext  = MGB'(sample0_ff);
      mag1_in   = (samp_ext >= dc) ? (samp_ext - dc) : (dc - samp_ext);

      // stage 2: square, low bits only feed the wrapping accumulator
      sq_full   = mag1_ff * mag1_ff;
      sq2_in    = sq_full[AVB-1:0];

      // stage 3: mean-square smoothing
      av_acc_in = av_acc_ff - (av_acc_ff >> av_shift_ff) + sq2_ff;
      av_sum    = {1'b0, av_acc_in} + {1'b0, av_acc_ff};
      ms3_in    = dcms_pkg::OUT_BITS'(av_sum >> av_sh1);

      sample0_in = req_ch.sample;

      v0_in = ld0 ? req_ch.valid : v0_ff;
      v1_in = ld1 ? v0_ff : v1_ff;
      v2_in = ld2 ? v1_ff : v2_ff;
      v3_in = ld3 ? v2_ff : v3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hp_shift_ff <= dcms_pkg::HIGHPASS_SHIFT_RST;
         av_shift_ff <= dcms_pkg::AVERAGE_SHIFT_RST;
         hp_acc_ff   <= '0;
         av_acc_ff   <= '0;
         v0_ff       <= 1'b0;
         v1_ff       <= 1'b0;
         v2_ff       <= 1'b0;
         v3_ff       <= 1'b0;
      end else begin
         hp_shift_ff <= hp_shift_in;
         av_shift_ff <= av_shift_in;
         v0_ff       <= v0_in;
         v1_ff       <= v1_in;
         v2_ff       <= v2_in;
         v3_ff       <= v3_in;
         if (ld1 && v0_ff) begin
            hp_acc_ff <= hp_acc_in;
         end
         if (ld3 && v2_ff) begin
            av_acc_ff <= av_acc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ld0) begin
         sample0_ff <= sample0_in;
      end
      if (ld1) begin
         mag1_ff <= mag1_in;
      end
      if (ld2) begin
         sq2_ff <= sq2_in;
      end
      if (ld3) begin
         ms3_ff <= ms3_in;
      end
   end

endmodule

// ----- src/dcms_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcms_checker
// Port-level checks for the mean-square detector, bound to the top level.
// ----------------------------------------------------------------------------
module dcms_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [dcms_pkg::OUT_BITS-1:0] rsp_mean_square
);

   // stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // stalled result payload is stable
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_mean_square))
      else $error("result changed while stalled");

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a draining receiver never throttles the input
   a_full_rate: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("input stalled while output drains");

endmodule

bind dc_blocked_mean_square_detector_top dcms_checker u_dcms_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_mean_square (rsp_ch.mean_square)
);

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the DC-blocked mean-square detector: streams
// samples through valid/ready channels with random gaps and back-pressure,
// predicts every mean-square value in a bit-exact software model and checks
// each response in order across many shift settings, clamped settings and a
// retune that drives the averaging accumulator past its width.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int SAMPLE_W     = dcms_pkg::SAMPLE_BITS_DEFAULT;
   localparam int SAMPLE_MAX   = (1 << SAMPLE_W) - 1;
   localparam int SHW          = dcms_pkg::SHIFT_BITS;
   localparam int OUTW         = dcms_pkg::OUT_BITS;
   localparam int DRAIN_CYCLES = 8;
   localparam int MAX_REPORTS  = 20;

   typedef enum int {
      SHAPE_UNIFORM,
      SHAPE_DC_NOISE,
      SHAPE_SQUARE,
      SHAPE_RAMP
   } stream_shape_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [dcms_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic [dcms_pkg::CSR_DATA_BITS-1:0]  csr_wr_data;

   dcms_req_if #(.SAMPLE_BITS(SAMPLE_W)) req_ch ();
   dcms_rsp_if rsp_ch ();

   dc_blocked_mean_square_detector_top #(.SAMPLE_BITS(SAMPLE_W)) uut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // detector model state
   logic [SHW-1:0] hp_shift_cfg;
   logic [SHW-1:0] av_shift_cfg;
   logic [63:0]    dc_acc;
   logic [63:0]    ms_acc;

   logic [OUTW-1:0] expected_ms[$];

   int req_gap_pct;
   int rsp_stall_pct;
   int unsigned sent_count;
   int unsigned checked_count;
   int unsigned error_count;
   int unsigned setting_count;

   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #4_000_000;
      $display("TIMEOUT at %0t: %0d results still pending", $realtime, expected_ms.size());
      $display("tb_top NOT OK");
      $finish;
   end

   function automatic int active_shift(input logic [SHW-1:0] v);
      if (v < dcms_pkg::SHIFT_MIN) begin
         return int'(dcms_pkg::SHIFT_MIN);
      end
      if (v > dcms_pkg::SHIFT_MAX) begin
         return int'(dcms_pkg::SHIFT_MAX);
      end
      return int'(v);
   endfunction

   function automatic logic [OUTW-1:0] advance_detector(input logic [SAMPLE_W-1:0] s);
      int k;
      int m;
      logic [63:0] x;
      logic [63:0] dc_old;
      logic [63:0] dc_new;
      logic [63:0] dc_level;
      logic [63:0] mag;
      logic [63:0] sq;
      logic [63:0] ms_old;
      logic [63:0] ms_new;
      logic [63:0] smooth;
      k      = active_shift(hp_shift_cfg);
      m      = active_shift(av_shift_cfg);
      x      = 64'(s);
      dc_old = dc_acc;
      dc_new = (dc_old - (dc_old >> k) + x) & 64'h0000_0000_FFFF_FFFF;
      dc_acc = dc_new;
      dc_level = (dc_new + dc_old) >> (k + 1);
      mag    = (x >= dc_level) ? (x - dc_level) : (dc_level - x);
      sq     = mag * mag;
      ms_old = ms_acc;
      ms_new = (ms_old - (ms_old >> m) + sq) & 64'h0000_00FF_FFFF_FFFF;
      ms_acc = ms_new;
      smooth = (ms_new + ms_old) >> (m + 1);
      return smooth[OUTW-1:0];
   endfunction

   function automatic int pick_idle(input int pct);
      if (int'($urandom_range(99)) >= pct) begin
         return 0;
      end
      if ($urandom_range(9) == 0) begin
         return int'($urandom_range(40, 12));
      end
      return int'($urandom_range(3, 1));
   endfunction

   function automatic logic [SAMPLE_W-1:0] make_sample(input stream_shape_type shape,
                                                       input int idx, input int level);
      int v;
      case (shape)
         SHAPE_DC_NOISE: begin
            v = level + int'($urandom_range(128)) - 64;
         end
         SHAPE_SQUARE: begin
            v = ((idx >> 3) & 1) ? SAMPLE_MAX - int'($urandom_range(15))
                                 : int'($urandom_range(15));
         end
         SHAPE_RAMP: begin
            v = (idx * 97 + level) % (SAMPLE_MAX + 1);
         end
         default: begin
            v = int'($urandom_range(SAMPLE_MAX));
         end
      endcase
      if (v < 0) v = 0;
      if (v > SAMPLE_MAX) v = SAMPLE_MAX;
      return v[SAMPLE_W-1:0];
   endfunction

   // response back-pressure
   initial begin
      int stall;
      rsp_ch.ready <= 1'b0;
      stall = 0;
      forever begin
         @(posedge clock);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            stall--;
         end else begin
            rsp_ch.ready <= 1'b1;
            stall = pick_idle(rsp_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      logic [OUTW-1:0] want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_ms.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS) begin
               $display("ERROR %0t: unexpected result, expected none actual mean_square=%0d",
                        $realtime, rsp_ch.mean_square);
            end
         end else begin
            want = expected_ms.pop_front();
            checked_count++;
            if (rsp_ch.mean_square !== want) begin
               error_count++;
               if (error_count <= MAX_REPORTS) begin
                  $display("ERROR %0t: mean_square expected=%0d actual=%0d",
                           $realtime, want, rsp_ch.mean_square);
               end
            end
         end
      end
   end

   task automatic send_sample(input logic [SAMPLE_W-1:0] s);
      int gap;
      gap = pick_idle(req_gap_pct);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.sample <= s;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      expected_ms.push_back(advance_detector(s));
      sent_count++;
   endtask

   task automatic wait_for_results();
      req_ch.valid <= 1'b0;
      while (expected_ms.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // call only while the pipeline is empty
   task automatic program_shifts(input logic [SHW-1:0] k,
                                 input logic [SHW-1:0] m);
      csr_wr_en   <= 1'b1;
      csr_index   <= dcms_pkg::CSR_HIGHPASS_SHIFT;
      csr_wr_data <= k;
      @(posedge clock);
      csr_index   <= dcms_pkg::CSR_AVERAGE_SHIFT;
      csr_wr_data <= m;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      hp_shift_cfg = k;
      av_shift_cfg = m;
      setting_count++;
      @(posedge clock);
   endtask

   task automatic test_reset_defaults();
      req_gap_pct   = 0;
      rsp_stall_pct = 0;
      send_sample(12'd0);
      send_sample(12'(SAMPLE_MAX));
      send_sample(12'(SAMPLE_MAX));
      send_sample(12'd0);
      send_sample(12'd2048);
      send_sample(12'd2047);
      send_sample(12'd1);
      send_sample(12'(SAMPLE_MAX - 1));
      wait_for_results();
   endtask

   task automatic test_shift_limits();
      logic [SHW-1:0] k_list[5];
      logic [SHW-1:0] m_list[5];
      k_list = '{5'd0, 5'd31, 5'd16, 5'd1, 5'd17};
      m_list = '{5'd0, 5'd31, 5'd1, 5'd16, 5'd20};
      req_gap_pct   = 30;
      rsp_stall_pct = 30;
      for (int i = 0; i < 5; i++) begin
         program_shifts(k_list[i], m_list[i]);
         send_sample(12'(SAMPLE_MAX));
         send_sample(12'd0);
         send_sample(make_sample(SHAPE_UNIFORM, i, 0));
         wait_for_results();
      end
   endtask

   // long slow charge, then a fast retune: huge highpass value, wrapped square sum
   task automatic test_retune_after_charge();
      req_gap_pct   = 10;
      rsp_stall_pct = 10;
      program_shifts(5'd16, 5'd16);
      for (int i = 0; i < 750; i++) begin
         send_sample(12'($urandom_range(SAMPLE_MAX, SAMPLE_MAX - 63)));
      end
      wait_for_results();
      program_shifts(5'd1, 5'd1);
      for (int i = 0; i < 20; i++) begin
         send_sample(make_sample(SHAPE_UNIFORM, i, 0));
      end
      wait_for_results();
   endtask

   task automatic test_random_streams();
      int pct_choice[3];
      stream_shape_type shape;
      int level;
      logic [SHW-1:0] k;
      logic [SHW-1:0] m;
      pct_choice = '{0, 20, 60};
      for (int phase = 0; phase < 10; phase++) begin
         k = ($urandom_range(9) < 7) ? SHW'($urandom_range(16, 1))
                                     : SHW'($urandom_range(31));
         m = ($urandom_range(9) < 7) ? SHW'($urandom_range(16, 1))
                                     : SHW'($urandom_range(31));
         program_shifts(k, m);
         req_gap_pct   = pct_choice[$urandom_range(2)];
         rsp_stall_pct = pct_choice[$urandom_range(2)];
         shape = stream_shape_type'($urandom_range(3));
         level = int'($urandom_range(SAMPLE_MAX));
         for (int i = 0; i < 40; i++) begin
            send_sample(make_sample(shape, i, level));
         end
         wait_for_results();
      end
   endtask

   initial begin
      reset         <= 1'b1;
      req_ch.valid  <= 1'b0;
      req_ch.sample <= '0;
      csr_wr_en     <= 1'b0;
      csr_index     <= dcms_pkg::CSR_HIGHPASS_SHIFT;
      csr_wr_data   <= '0;
      hp_shift_cfg  = dcms_pkg::HIGHPASS_SHIFT_RST;
      av_shift_cfg  = dcms_pkg::AVERAGE_SHIFT_RST;
      dc_acc        = '0;
      ms_acc        = '0;
      req_gap_pct   = 0;
      rsp_stall_pct = 0;
      sent_count    = 0;
      checked_count = 0;
      error_count   = 0;
      setting_count = 1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_shift_limits();
      test_retune_after_charge();
      test_random_streams();
      wait_for_results();

      $display("Sent %0d samples over %0d shift settings; %0d results checked.",
               sent_count, setting_count, checked_count);
      $display("Covered default and clamped shifts, idle/stall mixes and a wrapping retune.");
      if (error_count == 0 && expected_ms.size() == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule
